[sv/ffgs_pkg.sv]
// ----------------------------------------------------------------------------
// ffgs_pkg
// Shared types and constants of the forest fire grid step unit.
// ----------------------------------------------------------------------------
package ffgs_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned CoordW = 6;
  localparam int unsigned CellW  = 2;
  localparam int unsigned SideW  = 7;

  localparam logic [SideW-1:0] GridSideRst = 7'd64;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_e;

  typedef enum logic [CellW-1:0] {
    CELL_EMPTY = 2'd0,
    CELL_TREE  = 2'd1,
    CELL_FIRE  = 2'd2
  } cell_e;

  // neighbor visit order within one cell
  typedef enum logic [2:0] {
    NB_CENTER = 3'd0,
    NB_UP     = 3'd1,
    NB_DOWN   = 3'd2,
    NB_LEFT   = 3'd3,
    NB_RIGHT  = 3'd4
  } nb_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic cap;         // latch item kind and read bounds flag
    logic host_wr;     // host cell write into current bank
    logic scan_step;   // issue one scan read, advance scan counters
    logic swap;        // toggle current bank
    logic out_load;    // load result register
    logic out_src_in;  // result kind from the live input word
    logic out_rd;      // result cell from read data
  } ffgs_cmd_t;

  typedef struct packed {
    logic side_zero;
    logic scan_last;
    logic out_free;
  } ffgs_status_t;

endpackage

[sv/ffgs_ctrl.sv]
// ----------------------------------------------------------------------------
// ffgs_ctrl
// Item sequencer: decodes accepted words and steps the generation scan.
// ----------------------------------------------------------------------------
module ffgs_ctrl import ffgs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_accept_i,
  input  logic [KindW-1:0] in_kind_i,
  input  ffgs_status_t  status_i,
  output logic          in_ready_o,
  output ffgs_cmd_t     cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept_i) begin
          if (in_kind_i == KIND_READ) begin
            state_d = ST_RDWAIT;
          end else if (in_kind_i == KIND_ADVANCE && !status_i.side_zero) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_RDWAIT: state_d = ST_IDLE;
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_accept_i) begin
          cmd_o.cap = 1'b1;
          case (in_kind_i)
            KIND_WRITE: begin
              cmd_o.host_wr    = 1'b1;
              cmd_o.out_load   = 1'b1;
              cmd_o.out_src_in = 1'b1;
            end
            KIND_READ: begin
            end
            KIND_ADVANCE: begin
              if (status_i.side_zero) begin
                cmd_o.swap       = 1'b1;
                cmd_o.out_load   = 1'b1;
                cmd_o.out_src_in = 1'b1;
              end
            end
            default: begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_src_in = 1'b1;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_rd   = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o.swap     = 1'b1;
        cmd_o.out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/ffgs_dp.sv]
// ----------------------------------------------------------------------------
// ffgs_dp
// Datapath: two cell banks, scan counters, neighbor accumulation and the
// result register.
// ----------------------------------------------------------------------------
module ffgs_dp import ffgs_pkg::*; #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SideW-1:0]  cfg_wdata_i,
  input  logic [KindW-1:0]  in_kind_i,
  input  logic [CoordW-1:0] in_row_i,
  input  logic [CoordW-1:0] in_col_i,
  input  logic [CellW-1:0]  in_cell_i,
  input  ffgs_cmd_t         cmd_i,
  output ffgs_status_t      status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [CellW-1:0]  out_cell_o,
  output logic [KindW-1:0]  out_kind_o
);

  localparam int unsigned CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned NW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned AW    = 2 * CW;
  localparam int unsigned Depth = 1 << AW;

  logic [SideW-1:0] grid_side_q;
  logic [NW-1:0]    side;
  logic             in_grid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GridSideRst;
    end else if (cfg_we_i) begin
      grid_side_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (32'(grid_side_q) > MAX_SIDE) begin
      side = NW'(MAX_SIDE);
    end else begin
      side = NW'(grid_side_q);
    end
  end

  assign in_grid = (32'(in_row_i) < 32'(side)) && (32'(in_col_i) < 32'(side));

  // scan counters
  logic [CW-1:0] r_q, r_d, c_q, c_d;
  logic [2:0]    k_q, k_d;
  logic          r_end, c_end;

  assign r_end = (32'(r_q) + 32'd1) == 32'(side);
  assign c_end = (32'(c_q) + 32'd1) == 32'(side);

  always_comb begin
    r_d = r_q;
    c_d = c_q;
    k_d = k_q;
    if (cmd_i.scan_step) begin
      if (k_q == NB_RIGHT) begin
        k_d = NB_CENTER;
        if (c_end) begin
          c_d = '0;
          r_d = r_end ? '0 : r_q + CW'(1);
        end else begin
          c_d = c_q + CW'(1);
        end
      end else begin
        k_d = k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      c_q <= '0;
      k_q <= NB_CENTER;
    end else begin
      r_q <= r_d;
      c_q <= c_d;
      k_q <= k_d;
    end
  end

  // scan read address and neighbor bounds
  logic [CW-1:0] nr, nc;
  logic          nb_ok;

  always_comb begin
    nr    = r_q;
    nc    = c_q;
    nb_ok = 1'b1;
    case (k_q)
      NB_UP: begin
        nr    = r_q - CW'(1);
        nb_ok = (r_q != '0);
      end
      NB_DOWN: begin
        nr    = r_q + CW'(1);
        nb_ok = !r_end;
      end
      NB_LEFT: begin
        nc    = c_q - CW'(1);
        nb_ok = (c_q != '0);
      end
      NB_RIGHT: begin
        nc    = c_q + CW'(1);
        nb_ok = !c_end;
      end
      default: begin
      end
    endcase
  end

  logic [AW-1:0] host_addr, raddr;

  assign host_addr = {CW'(in_row_i), CW'(in_col_i)};
  assign raddr     = cmd_i.scan_step ? {nr, nc} : host_addr;

  // read tag pipeline
  logic          tag_vld_q;
  logic [2:0]    tag_k_q;
  logic          tag_ok_q;
  logic [AW-1:0] tag_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q <= 1'b0;
    end else begin
      tag_vld_q <= cmd_i.scan_step;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_k_q    <= k_q;
    tag_ok_q   <= nb_ok;
    tag_addr_q <= {r_q, c_q};
  end

  // cell banks
  logic [CellW-1:0] bank_a [Depth];
  logic [CellW-1:0] bank_b [Depth];
  logic [CellW-1:0] rd_a_q, rd_b_q, rdata;
  logic             cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 1'b0;
    end else if (cmd_i.swap) begin
      cur_q <= !cur_q;
    end
  end

  assign rdata = cur_q ? rd_b_q : rd_a_q;

  logic             hit, host_we, scan_we, we_a, we_b;
  logic [CellW-1:0] center_q, fire_acc_q, new_cell, wdata;
  logic [AW-1:0]    waddr;

  assign hit     = tag_ok_q && (rdata == CELL_FIRE);
  assign host_we = cmd_i.host_wr && in_grid && (in_cell_i != 2'd3);
  assign scan_we = tag_vld_q && (tag_k_q == NB_RIGHT);

  always_comb begin
    if (center_q == CELL_TREE) begin
      new_cell = (fire_acc_q[0] || hit) ? CELL_FIRE : CELL_TREE;
    end else begin
      new_cell = CELL_EMPTY;
    end
  end

  assign wdata = scan_we ? new_cell : in_cell_i;
  assign waddr = scan_we ? tag_addr_q : host_addr;
  assign we_a  = (host_we && !cur_q) || (scan_we && cur_q);
  assign we_b  = (host_we && cur_q) || (scan_we && !cur_q);

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      bank_a[waddr] <= wdata;
    end
    rd_a_q <= bank_a[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      bank_b[waddr] <= wdata;
    end
    rd_b_q <= bank_b[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tag_vld_q) begin
      if (tag_k_q == NB_CENTER) begin
        center_q   <= rdata;
        fire_acc_q <= '0;
      end else begin
        fire_acc_q <= {1'b0, fire_acc_q[0] | hit};
      end
    end
  end

  // item capture and result register
  logic [KindW-1:0] kind_q;
  logic             rd_inside_q;
  logic             out_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q      <= in_kind_i;
      rd_inside_q <= in_grid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_cell_o <= (cmd_i.out_rd && rd_inside_q) ? rdata : CELL_EMPTY;
      out_kind_o <= cmd_i.out_src_in ? in_kind_i : kind_q;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign status_o.out_free  = !out_vld_q || out_ready_i;
  assign status_o.side_zero = (side == '0);
  assign status_o.scan_last = (k_q == NB_RIGHT) && r_end && c_end;

  a_scan_host_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_we |-> !host_we)
    else $error("scan write collides with host write");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_vld_q || out_ready_i))
    else $error("result register overwritten");

  a_step_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (side != '0))
    else $error("scan on empty grid");

  a_swap_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.swap |=> (cur_q != $past(cur_q)))
    else $error("bank swap lost");

endmodule

[sv/forest_fire_grid_step_unit.sv]
// ----------------------------------------------------------------------------
// forest_fire_grid_step_unit
// Forest fire automaton on a square grid of two-bit cells with double banks.
// ----------------------------------------------------------------------------
// One word in gives one word out. An advance visits every cell of the grid
// through the single read port of the current bank, once for the cell and
// once for each of its four neighbors, while the new state goes into the
// other bank; an advance with a side of zero swaps the banks without a scan.
// Banks need no clearing after reset; read only cells that were written.
// A new word is taken only when the result register is empty or its word
// leaves in the same cycle.
module forest_fire_grid_step_unit import ffgs_pkg::*; #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SideW-1:0]  cfg_wdata_i,    // grid_side
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // row[5:0], column[11:6], cell_in[13:12]
  input  logic [KindW-1:0]  s_axis_tuser,   // kind[1:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // cell_out[1:0]
  output logic [KindW-1:0]  m_axis_tuser    // done_kind[1:0]
);

  ffgs_cmd_t        cmd;
  ffgs_status_t     status;
  logic             in_accept;
  logic [CellW-1:0] out_cell;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  ffgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_kind_i   (s_axis_tuser),
    .status_i    (status),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  ffgs_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_kind_i   (s_axis_tuser),
    .in_row_i    (s_axis_tdata[5:0]),
    .in_col_i    (s_axis_tdata[11:6]),
    .in_cell_i   (s_axis_tdata[13:12]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_cell_o  (out_cell),
    .out_kind_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, out_cell};

endmodule
